@@ hw/rtl/seg_pkg.sv @@
// ----------------------------------------------------------------------------
// seg_pkg
// Shared types and constants of the shaped envelope gain block: field widths,
// the envelope node record and the divider request/response structs.
// ----------------------------------------------------------------------------
`default_nettype none

package seg_pkg;

   localparam int FREQ_W      = 24;
   localparam int GAIN_W      = 16;
   localparam int SHAPE_W     = 16;
   localparam int AMP_W       = 16;
   localparam int INDEX_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 40;

   // Divider: 16 quotient bits, remainder wide enough for the curve denominator
   localparam int DIV_W  = 34;
   localparam int QUO_W  = 16;
   localparam int QCNT_W = $clog2(QUO_W);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic signed [SHAPE_W-1:0] SHAPE_MIN = -16'sd32767;

   typedef struct packed {
      logic        [FREQ_W-1:0]  freq;
      logic        [GAIN_W-1:0]  gain;
      logic signed [SHAPE_W-1:0] shape;
   } seg_node_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] rem_init;
      logic [DIV_W-1:0] divisor;
   } seg_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } seg_div_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/seg_div.sv @@
// ----------------------------------------------------------------------------
// seg_div
// Restoring divider, one quotient bit per cycle. The starting remainder must
// be below the divisor, which bounds the quotient to QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module seg_div (
   input  wire                      clock,
   input  wire                      reset,
   input  seg_pkg::seg_div_req_type div_req,
   output seg_pkg::seg_div_rsp_type div_rsp
);
   import seg_pkg::*;

   localparam logic [QCNT_W-1:0] CNT_LAST = QCNT_W'(QUO_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;

   logic [DIV_W-1:0]  rem_dbl;
   logic              fits;

   assign rem_dbl = {rem_ff[DIV_W-2:0], 1'b0};
   assign fits    = rem_dbl >= div_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      done_in = busy_ff && (cnt_ff == CNT_LAST);
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.rem_init;
         div_in  = div_req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + QCNT_W'(1);
         rem_in = fits ? (rem_dbl - div_ff) : rem_dbl;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTH
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < div_ff))
      else $error("divider remainder reached the divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/shaped_envelope_gain.sv @@
// ----------------------------------------------------------------------------
// shaped_envelope_gain
// Breakpoint envelope gain with shaped segments applied to a query amplitude.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes one node (frequency, gain, segment shape)
// into the node memory. A query transaction (tuser 1) reads the nodes one per
// cycle from the memory, stops at the first segment holding the frequency, then
// runs two divisions on a shared restoring divider (segment position t, then the
// shaped curve), each waited on until the divider reports done, and a short
// multiply chain before the result is registered. A query holds the input until
// its result goes out. A query that falls outside every segment skips the
// divisions, and one with no active nodes goes straight to the output step.
// One transaction is in work at a time, while a finished result may still wait
// on rsp_tready; a result still waiting holds the next query at its output step.
// csr_data sets the active node count (values above MAX_NODES act as
// MAX_NODES) and must only be written while the block is idle.
`default_nettype none

module shaped_envelope_gain #(
   parameter int MAX_NODES = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // node_index, node_freq, node_gain, node_shape, query_freq, query_amp, pad
   input  wire  [seg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type
   input  wire                              req_tuser,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // out_freq, out_amp
   output logic [seg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [seg_pkg::COUNT_W-1:0]      csr_data,
   input  wire                              csr_valid,
   output logic                             csr_ready
);
   import seg_pkg::*;

   localparam int AW = $clog2(MAX_NODES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SCAN = 4'd1;
   localparam logic [3:0] ST_D1   = 4'd2;
   localparam logic [3:0] ST_W1   = 4'd3;
   localparam logic [3:0] ST_MP   = 4'd4;
   localparam logic [3:0] ST_MS   = 4'd5;
   localparam logic [3:0] ST_D2   = 4'd6;
   localparam logic [3:0] ST_W2   = 4'd7;
   localparam logic [3:0] ST_MA   = 4'd8;
   localparam logic [3:0] ST_MB   = 4'd9;
   localparam logic [3:0] ST_AMP  = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   // request fields
   logic [INDEX_W-1:0]        req_index;
   seg_node_type              req_node;
   logic [FREQ_W-1:0]         req_qfreq;
   logic [AMP_W-1:0]          req_qamp;

   assign req_index      = req_tdata[3:0];
   assign req_node.freq  = req_tdata[27:4];
   assign req_node.gain  = req_tdata[43:28];
   assign req_node.shape = req_tdata[59:44];
   assign req_qfreq      = req_tdata[83:60];
   assign req_qamp       = req_tdata[99:84];

   // control state
   logic [3:0]         state_ff, state_in;
   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic [AW-1:0]        last_idx_ff, last_idx_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [AMP_W-1:0]     amp_ff, amp_in;
   logic [FREQ_W-1:0]    first_x_ff, first_x_in;
   logic [GAIN_W-1:0]    first_g_ff, first_g_in;
   seg_node_type         prev_ff, prev_in;
   logic [FREQ_W-1:0]    fo_ff, fo_in;
   logic [FREQ_W-1:0]    d_ff, d_in;
   logic [GAIN_W-1:0]    g0_ff, g0_in;
   logic [GAIN_W-1:0]    g1_ff, g1_in;
   logic [SHAPE_W-1:0]   s_ff, s_in;
   logic [QUO_W-1:0]     t_ff, t_in;
   logic [QUO_W-1:0]     c_ff, c_in;
   logic [31:0]          p_ff, p_in;
   logic signed [32:0]   st_ff, st_in;
   logic [31:0]          acc_ff, acc_in;
   logic [AMP_W-1:0]     res_ff, res_in;
   logic [FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;
   logic [AMP_W-1:0]     rsp_amp_ff, rsp_amp_in;

   // node memory
   seg_node_type         node_mem [MAX_NODES];
   seg_node_type         mem_q_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;

   seg_div_req_type      div_req;
   seg_div_rsp_type      div_rsp;

   logic                 req_acc;
   logic [31:0]          n_lim;
   logic                 hit;
   logic                 at_last;
   logic [FREQ_W-1:0]    x_first;
   logic [GAIN_W-1:0]    g_first;
   logic [GAIN_W-1:0]    g_fall;
   logic [16:0]          s_ext;
   logic [16:0]          a_sum;
   logic [16:0]          b_sum;
   logic [16:0]          c_inv;
   logic [31:0]          prod;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign wr_en = req_acc && (req_tuser == REQ_LOAD) && (32'(req_index) < 32'(MAX_NODES));
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : (rd_idx_ff + AW'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[AW'(req_index)] <= req_node;
      end
      mem_q_ff <= node_mem[rd_addr];
   end

   assign n_lim = (32'(node_count_ff) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                         : 32'(node_count_ff);

   assign hit     = (rd_idx_ff != '0) && (freq_ff >= prev_ff.freq)
                    && (freq_ff < mem_q_ff.freq);
   assign at_last = (rd_idx_ff == last_idx_ff);
   assign x_first = (rd_idx_ff == '0) ? mem_q_ff.freq : first_x_ff;
   assign g_first = (rd_idx_ff == '0) ? mem_q_ff.gain : first_g_ff;
   assign g_fall  = (freq_ff <= x_first) ? g_first : mem_q_ff.gain;

   assign s_ext = {s_ff[SHAPE_W-1], s_ff};
   assign a_sum = 17'h08000 + s_ext;
   assign b_sum = 17'h08000 - s_ext;
   assign c_inv = 17'h10000 - {1'b0, c_ff};
   assign prod  = 32'(amp_ff) * 32'(acc_ff[31:16]);

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_valid ? csr_data : node_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rd_idx_in     = rd_idx_ff;
      last_idx_in   = last_idx_ff;
      freq_in       = freq_ff;
      amp_in        = amp_ff;
      first_x_in    = first_x_ff;
      first_g_in    = first_g_ff;
      prev_in       = prev_ff;
      fo_in         = fo_ff;
      d_in          = d_ff;
      g0_in         = g0_ff;
      g1_in         = g1_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      c_in          = c_ff;
      p_in          = p_ff;
      st_in         = st_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_amp_in    = rsp_amp_ff;
      div_req       = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == REQ_QUERY)) begin
               freq_in     = req_qfreq;
               amp_in      = req_qamp;
               res_in      = req_qamp;
               rd_idx_in   = '0;
               last_idx_in = AW'(n_lim - 32'd1);
               state_in    = (node_count_ff == '0) ? ST_OUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == '0) begin
               first_x_in = mem_q_ff.freq;
               first_g_in = mem_q_ff.gain;
            end
            if (hit) begin
               fo_in    = freq_ff - prev_ff.freq;
               d_in     = mem_q_ff.freq - prev_ff.freq;
               g0_in    = prev_ff.gain;
               g1_in    = mem_q_ff.gain;
               s_in     = (prev_ff.shape < SHAPE_MIN) ? SHAPE_MIN : prev_ff.shape;
               state_in = ST_D1;
            end else if (at_last) begin
               acc_in   = {g_fall, 16'h0000};
               state_in = ST_AMP;
            end else begin
               prev_in   = mem_q_ff;
               rd_idx_in = rd_idx_ff + AW'(1);
            end
         end
         ST_D1: begin
            div_req.start    = 1'b1;
            div_req.rem_init = DIV_W'(fo_ff);
            div_req.divisor  = DIV_W'(d_ff);
            state_in         = ST_W1;
         end
         ST_W1: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient;
               state_in = ST_MP;
            end
         end
         ST_MP: begin
            p_in     = 32'(a_sum[15:0]) * 32'(t_ff);
            state_in = ST_MS;
         end
         ST_MS: begin
            st_in    = 33'($signed(s_ff)) * 33'($signed({1'b0, t_ff}));
            state_in = ST_D2;
         end
         ST_D2: begin
            div_req.start    = 1'b1;
            div_req.rem_init = DIV_W'(p_ff);
            div_req.divisor  = {2'b00, b_sum[15:0], 16'h0000} + {st_ff, 1'b0};
            state_in         = ST_W2;
         end
         ST_W2: begin
            if (div_rsp.done) begin
               c_in     = div_rsp.quotient;
               state_in = ST_MA;
            end
         end
         ST_MA: begin
            acc_in   = 32'(g0_ff) * 32'(c_inv);
            state_in = ST_MB;
         end
         ST_MB: begin
            acc_in   = acc_ff + 32'(g1_ff) * 32'(c_ff);
            state_in = ST_AMP;
         end
         ST_AMP: begin
            res_in   = prod[31] ? '1 : prod[30:15];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = freq_ff;
               rsp_amp_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      freq_ff     <= freq_in;
      amp_ff      <= amp_in;
      first_x_ff  <= first_x_in;
      first_g_ff  <= first_g_in;
      prev_ff     <= prev_in;
      fo_ff       <= fo_in;
      d_ff        <= d_in;
      g0_ff       <= g0_in;
      g1_ff       <= g1_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      c_ff        <= c_in;
      p_ff        <= p_in;
      st_ff       <= st_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_amp_ff  <= rsp_amp_in;
   end

   seg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_amp_ff, rsp_freq_ff};

`ifndef SYNTH
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_idx_ff <= last_idx_ff))
      else $error("node scan ran past the last active node");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == ST_W1) || (state_ff == ST_W2)))
      else $error("divider finished outside a wait state");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside the output state");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == REQ_QUERY)) |=>
         ((state_ff == ST_SCAN) || (state_ff == ST_OUT)))
      else $error("query transaction did not start work");
`endif

endmodule

`default_nettype wire
